[rtl/sgtor_pkg.sv]
// ----------------------------------------------------------------------------
// sgtor_pkg: shared widths and codes for the segment tree OR block
// Field widths of the command and configuration ports, the reset value
// of the size register and the command codes.
// ----------------------------------------------------------------------------
package sgtor_pkg;

    localparam int DATA_W  = 64;
    localparam int INDEX_W = 10;
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

[rtl/segment_tree_range_or.sv]
// ----------------------------------------------------------------------------
// segment_tree_range_or: point update, range OR query segment tree
// A flat bottom-up segment tree of 64-bit words in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// A command is taken at a clock edge with start high and busy low. A set
// command (mode 0) writes one leaf and rewrites the OR on the path to the
// root: the leaf write and the sibling read share the accept cycle, then
// each tree level reads the sibling and writes the parent, and busy stays
// high until the root is written. A query command (mode 1) walks the left
// and right borders level by level; the single memory read port takes the
// left node in state ST_QL and the right node in state ST_QR, and the query
// ends with its result once the left border is no longer below the right.
// The result appears on o_range_or for exactly one cycle with o_done high;
// the receiver cannot stall it. Set commands give no result.
// The size register is written through i_cfg_valid/o_cfg_ready (always
// ready). After reset and after every size write, a clearing pass zeroes
// all 2*MAX_ENTRIES memory entries, one entry per cycle, with busy high.
// ----------------------------------------------------------------------------
module segment_tree_range_or
    import sgtor_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [DATA_W-1:0]  i_value,
    input  logic [INDEX_W-1:0] i_range_low,
    input  logic [INDEX_W-1:0] i_range_high,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    output logic               o_done,
    output logic [DATA_W-1:0]  o_range_or
);

    localparam int DEPTH = 2 * MAX_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = (NW > SIZE_W) ? NW : SIZE_W;
    localparam int USED_RESET = (int'(SIZE_RESET) > MAX_ENTRIES) ?
                                MAX_ENTRIES : int'(SIZE_RESET);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_UP,
        ST_QL,
        ST_QR
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [CW-1:0]     r_used;
    logic [NW-1:0]     r_p, n_p;
    logic [NW-1:0]     r_l, n_l;
    logic [NW-1:0]     r_r, n_r;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_pend, n_pend;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_range_or, n_range_or;
    logic [DATA_W-1:0] r_rdata;

    logic [DATA_W-1:0] mem [DEPTH];
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    logic [CW-1:0]     cfg_e, used_cfg;
    logic [CW-1:0]     idx_e, idx_c, leaf_w;
    logic [CW-1:0]     lo_e, hi_e, hi_c, l_w, r_w;
    logic              q_empty;
    logic [NW-1:0]     leaf, par, l1, r1;
    logic [DATA_W-1:0] acc_in, up_val;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_range_or  = r_range_or;

    // Size register value as the tree uses it: zero acts as one, and
    // anything beyond the tree capacity acts as the capacity.
    always_comb begin
        cfg_e = CW'(i_cfg_data);
        if (cfg_e == '0) begin
            used_cfg = CW'(1);
        end else if (cfg_e > CW'(MAX_ENTRIES)) begin
            used_cfg = CW'(MAX_ENTRIES);
        end else begin
            used_cfg = cfg_e;
        end
    end

    // Command decode in the accept cycle.
    always_comb begin
        idx_e   = CW'(i_index);
        idx_c   = (idx_e >= r_used) ? r_used - CW'(1) : idx_e;
        leaf_w  = idx_c + CW'(MAX_ENTRIES);
        leaf    = leaf_w[NW-1:0];
        lo_e    = CW'(i_range_low);
        hi_e    = CW'(i_range_high);
        hi_c    = (hi_e > r_used - CW'(1)) ? r_used - CW'(1) : hi_e;
        q_empty = (lo_e > hi_c);
        l_w     = lo_e + CW'(MAX_ENTRIES);
        r_w     = hi_c + CW'(1) + CW'(MAX_ENTRIES);
    end

    always_comb begin
        par    = r_p >> 1;
        up_val = r_acc | r_rdata;
        acc_in = r_pend ? (r_acc | r_rdata) : r_acc;
        l1     = r_l + NW'(r_l[0]);
        r1     = r_r - NW'(r_r[0]);
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_p        = r_p;
        n_l        = r_l;
        n_r        = r_r;
        n_acc      = r_acc;
        n_pend     = r_pend;
        n_done     = 1'b0;
        n_range_or = r_range_or;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = '0;
        mem_raddr  = '0;
        mem_wdata  = '0;

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_mode == MODE_SET) begin
                        // Write the leaf and fetch its sibling together.
                        mem_we    = 1'b1;
                        mem_waddr = leaf[AW-1:0];
                        mem_wdata = i_value;
                        mem_re    = 1'b1;
                        mem_raddr = {leaf[AW-1:1], ~leaf[0]};
                        n_p       = leaf;
                        n_acc     = i_value;
                        n_state   = ST_UP;
                    end else begin
                        n_acc   = '0;
                        n_pend  = 1'b0;
                        n_l     = q_empty ? '0 : l_w[NW-1:0];
                        n_r     = q_empty ? '0 : r_w[NW-1:0];
                        n_state = ST_QL;
                    end
                end
            end
            ST_UP: begin
                // The node just written is held in r_acc, so only its
                // sibling comes from memory; the parent is written now.
                mem_we    = 1'b1;
                mem_waddr = par[AW-1:0];
                mem_wdata = up_val;
                n_acc     = up_val;
                n_p       = par;
                if (par == NW'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = {par[AW-1:1], ~par[0]};
                end
            end
            ST_QL: begin
                // Absorbs the right border read of the previous level.
                n_acc  = acc_in;
                n_pend = 1'b0;
                if (r_l < r_r) begin
                    if (r_l[0]) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_l[AW-1:0];
                    end
                    n_pend  = r_l[0];
                    n_state = ST_QR;
                end else begin
                    n_done     = 1'b1;
                    n_range_or = acc_in;
                    n_state    = ST_IDLE;
                end
            end
            ST_QR: begin
                n_acc = acc_in;
                if (r_r[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = r1[AW-1:0];
                end
                n_pend  = r_r[0];
                n_l     = l1 >> 1;
                n_r     = r1 >> 1;
                n_state = ST_QL;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr      <= '0;
            r_used     <= CW'(USED_RESET);
            r_pend     <= 1'b0;
            r_done     <= 1'b0;
            r_range_or <= '0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_pend     <= n_pend;
            r_done     <= n_done;
            r_range_or <= n_range_or;
            // A size write rebuilds the tree, so the store is cleared.
            if (i_cfg_valid && o_cfg_ready) begin
                r_used  <= used_cfg;
                r_state <= ST_CLR;
                r_clr   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_l   <= n_l;
        r_r   <= n_r;
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    a_done_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == ST_QL)
        else $error("result strobe without a finished query");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("memory read and write hit the same node in one cycle");

    a_no_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_CLR) |-> (mem_waddr != '0))
        else $error("tree update wrote the unused node zero");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_state == ST_CLR && r_clr == '0))
        else $error("size write did not restart the clearing pass");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule
